[rtl/core/dnacase_pkg.sv]
// ----------------------------------------------------------------------------
// dnacase_pkg: shared types and constants for the case/N/special extractor
// Transaction payload structs, result kind codes and character constants.
// ----------------------------------------------------------------------------
package dnacase_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       seq_end;
	} char_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] position;
		logic [30:0]        run_length;
		logic [7:0]         value;
		logic               last;
	} rec_item_t;

	localparam logic [1:0] KIND_BASE    = 2'd0;
	localparam logic [1:0] KIND_SPECIAL = 2'd1;
	localparam logic [1:0] KIND_LOWER   = 2'd2;
	localparam logic [1:0] KIND_NRUN    = 2'd3;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	localparam logic [7:0] CH_A        = 8'h41;
	localparam logic [7:0] CH_C        = 8'h43;
	localparam logic [7:0] CH_G        = 8'h47;
	localparam logic [7:0] CH_T        = 8'h54;
	localparam logic [7:0] CH_N        = 8'h4e;
	localparam logic [7:0] CH_LOW_A    = 8'h61;
	localparam logic [7:0] CH_LOW_Z    = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int MAX_RECS = 3;

endpackage

[rtl/core/dna_case_n_special_extract.sv]
// ----------------------------------------------------------------------------
// dna_case_n_special_extract: base, lowercase-run, N-run and special extractor
// ----------------------------------------------------------------------------
// Usage:
//   char_* carries one sequence character per transaction (valid/stall),
//   with seq_end on the final character. rec_* carries result records
//   (valid/stall). cfg_* (valid/ready, always ready) writes reference_mode;
//   write it only while the block is idle.
//   A character is classified and the run state updated in the cycle it is
//   accepted; its zero to three records land in a result register and show
//   on rec_* the next cycle, one record per unstalled cycle, last set on the final one.
//   Throughput: one character per cycle while each causes at most one
//   record and the receiver does not stall; a character causing more
//   records holds char_stall while the result register drains them one per cycle. The next
//   character is taken in the cycle the final pending record leaves.
//   A stalled receiver holds the current record and, once it is the final
//   pending one, stalls the character side too.
//   Reset clears all run state, indexes and reference_mode; no records are
//   pending. After a seq_end character the run state returns to zero.
//   The character index and run counts saturate at 2^POS_WIDTH - 1.
// ----------------------------------------------------------------------------
module dna_case_n_special_extract #(
	parameter int POS_WIDTH = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	input  logic                    char_valid,
	output logic                    char_stall,
	input  dnacase_pkg::char_item_t char_item,
	output logic                    rec_valid,
	input  logic                    rec_stall,
	output dnacase_pkg::rec_item_t  rec_item
);
	import dnacase_pkg::*;

	localparam int P  = POS_WIDTH;
	localparam int EW = (P + 1 > 32) ? P + 1 : 32;

	function automatic logic signed [31:0] gap_pos(input logic [P-1:0] g);
		logic [EW-1:0] e;
		e = EW'(g);
		return $signed(e[31:0]);
	endfunction

	function automatic logic signed [31:0] sgap_pos(input logic signed [P:0] g);
		logic signed [EW-1:0] e;
		e = EW'(g);
		return e[31:0];
	endfunction

	function automatic logic [30:0] run_len(input logic [P-1:0] c);
		logic [EW-1:0] e;
		e = EW'(c);
		return e[30:0];
	endfunction

	function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
		return (&v) ? v : v + P'(1);
	endfunction

	logic         mode_q;
	logic [P-1:0] idx_q;
	logic         lo_run_q;
	logic [P-1:0] lo_cnt_q, lo_gap_q, lo_anchor_q;
	logic         n_run_q;
	logic [P-1:0] n_cnt_q, n_gap_q, n_anchor_q;
	logic [P-1:0] spec_anchor_q;

	rec_item_t    rec_s1 [MAX_RECS];
	logic [1:0]   cnt_s1;

	logic         accept;
	logic         lower, is_base, is_n;
	logic [7:0]   cu;
	logic [1:0]   code;
	logic         lo_run_n, n_run_n;
	logic [P-1:0] lo_cnt_n, lo_gap_n, n_cnt_n, n_gap_n;
	logic signed [P:0] sp_diff;
	logic [3:0]   cv;
	rec_item_t    cand [4];
	rec_item_t    bundle [MAX_RECS];
	logic [1:0]   bundle_cnt;

	assign cfg_ready  = 1'b1;
	assign rec_valid  = (cnt_s1 != 2'd0);
	assign rec_item   = rec_s1[0];
	// take a new character only when the pending records empty this cycle
	assign char_stall = (cnt_s1 > 2'd1) || ((cnt_s1 == 2'd1) && rec_stall);
	assign accept     = char_valid && !char_stall;

	always_comb begin
		lower = (char_item.ch >= CH_LOW_A) && (char_item.ch <= CH_LOW_Z);
		cu    = lower ? char_item.ch - CASE_OFFSET : char_item.ch;
		is_base = 1'b1;
		code    = CODE_A;
		unique case (cu)
			CH_A: code = CODE_A;
			CH_C: code = CODE_C;
			CH_G: code = CODE_G;
			CH_T: code = CODE_T;
			default: is_base = 1'b0;
		endcase
		is_n = (cu == CH_N);

		lo_run_n = lo_run_q;
		lo_cnt_n = lo_cnt_q;
		lo_gap_n = lo_gap_q;
		if (lower) begin
			if (lo_run_q) begin
				lo_cnt_n = sat_inc(lo_cnt_q);
			end else begin
				lo_run_n = 1'b1;
				lo_cnt_n = P'(1);
				lo_gap_n = idx_q - lo_anchor_q;
			end
		end

		n_run_n = n_run_q;
		n_cnt_n = n_cnt_q;
		n_gap_n = n_gap_q;
		if (!mode_q && !is_base && is_n) begin
			if (n_run_q) begin
				n_cnt_n = sat_inc(n_cnt_q);
			end else begin
				n_run_n = 1'b1;
				n_cnt_n = P'(1);
				n_gap_n = idx_q - n_anchor_q;
			end
		end

		sp_diff = $signed({1'b0, idx_q}) - $signed({1'b0, spec_anchor_q}) - $signed((P+1)'(1));

		// candidate records in emission order
		cv[0] = mode_q && !lower && lo_run_q;
		cv[1] = is_base || (!mode_q && !is_n);
		cv[2] = mode_q ? (lower && char_item.seq_end)
		               : ((!lower || char_item.seq_end) && lo_run_n);
		cv[3] = !mode_q && (!is_n || char_item.seq_end) && n_run_n;

		cand[0] = '{kind: KIND_LOWER, position: gap_pos(lo_gap_q),
		            run_length: run_len(lo_cnt_q), value: 8'd0, last: 1'b0};
		cand[1] = '{kind: is_base ? KIND_BASE : KIND_SPECIAL,
		            position: is_base ? 32'sd0 : sgap_pos(sp_diff),
		            run_length: 31'd0,
		            value: is_base ? {6'd0, code} : cu, last: 1'b0};
		cand[2] = '{kind: KIND_LOWER, position: gap_pos(lo_gap_n),
		            run_length: run_len(lo_cnt_n), value: 8'd0, last: 1'b0};
		cand[3] = '{kind: KIND_NRUN, position: gap_pos(n_gap_n),
		            run_length: run_len(n_cnt_n), value: 8'd0, last: 1'b0};

		// pack enabled candidates; at most three are ever enabled together
		for (int k = 0; k < MAX_RECS; k++) begin
			bundle[k] = cand[0];
		end
		bundle_cnt = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (cv[k] && (bundle_cnt != 2'd3)) begin
				bundle[bundle_cnt] = cand[k];
				bundle_cnt         = bundle_cnt + 2'd1;
			end
		end
		if (bundle_cnt != 2'd0) begin
			bundle[bundle_cnt - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			lo_run_q      <= 1'b0;
			lo_cnt_q      <= '0;
			lo_gap_q      <= '0;
			lo_anchor_q   <= '0;
			n_run_q       <= 1'b0;
			n_cnt_q       <= '0;
			n_gap_q       <= '0;
			n_anchor_q    <= '0;
			spec_anchor_q <= '0;
		end else if (accept) begin
			if (char_item.seq_end) begin
				idx_q         <= '0;
				lo_run_q      <= 1'b0;
				lo_cnt_q      <= '0;
				lo_gap_q      <= '0;
				lo_anchor_q   <= '0;
				n_run_q       <= 1'b0;
				n_cnt_q       <= '0;
				n_gap_q       <= '0;
				n_anchor_q    <= '0;
				spec_anchor_q <= '0;
			end else begin
				idx_q    <= sat_inc(idx_q);
				lo_cnt_q <= lo_cnt_n;
				lo_gap_q <= lo_gap_n;
				n_cnt_q  <= n_cnt_n;
				n_gap_q  <= n_gap_n;
				lo_run_q <= lo_run_n && !(cv[0] || cv[2]);
				n_run_q  <= n_run_n && !cv[3];
				if (cv[0] || cv[2]) begin
					lo_anchor_q <= idx_q;
				end
				if (cv[3]) begin
					n_anchor_q <= idx_q;
				end
				if (cv[1] && !is_base) begin
					spec_anchor_q <= idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (accept) begin
			cnt_s1 <= bundle_cnt;
		end else if (rec_valid && !rec_stall) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	// advance the record queue toward the output slot
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= bundle;
		end else if (rec_valid && !rec_stall) begin
			rec_s1[0] <= rec_s1[1];
			rec_s1[1] <= rec_s1[2];
		end
	end

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> rec_valid)
		else $error("character side stalled with no pending record");

	a_end_clears_index: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && char_item.seq_end) |=> (idx_q == '0) && !lo_run_q && !n_run_q)
		else $error("run state not cleared after sequence end");

	a_lower_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		lo_run_q |-> (lo_cnt_q != '0))
		else $error("open lowercase run with zero count");

	a_n_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		n_run_q |-> (n_cnt_q != '0))
		else $error("open N run with zero count");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && !rec_stall && (cnt_s1 > 2'd1)) |=> rec_valid)
		else $error("pending records lost during drain");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && (cnt_s1 > 2'd1)) |-> !rec_item.last)
		else $error("last flag set before final record");

endmodule

[tb/dna_case_checker.sv]
// ----------------------------------------------------------------------------
// dna_case_checker: record predictor and scoreboard for the extractor
// Watches the config, character and record channels. Each accepted character
// is run through a local model of the run/special tracking state, and the
// records it should cause are queued. Each accepted record is compared field
// by field against the oldest queued one.
// ----------------------------------------------------------------------------
module dna_case_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic                    cfg_data,
	input  logic                    char_valid,
	input  logic                    char_stall,
	input  dnacase_pkg::char_item_t char_item,
	input  logic                    rec_valid,
	input  logic                    rec_stall,
	input  dnacase_pkg::rec_item_t  rec_item,
	output int                      fail_count,
	output int                      pending
);
	import dnacase_pkg::*;

	localparam int POS_WIDTH = 31;
	typedef logic [POS_WIDTH-1:0] pos_t;
	localparam pos_t POS_SAT = '1;

	logic        ref_mode;
	pos_t        char_idx;
	logic        low_open;
	pos_t        low_len;
	logic [31:0] low_gap;
	pos_t        low_anchor;
	logic        n_open;
	pos_t        n_len;
	logic [31:0] n_gap;
	pos_t        n_anchor;
	pos_t        spec_anchor;

	rec_item_t rec_expect[$];
	rec_item_t rec_batch[$];

	function automatic pos_t bump(input pos_t v);
		return (v == POS_SAT) ? v : v + 1'b1;
	endfunction

	function automatic logic [31:0] gap32(input pos_t a, input pos_t b);
		logic [63:0] d;
		d = 64'(a) - 64'(b);
		return d[31:0];
	endfunction

	function automatic rec_item_t make_rec(input logic [1:0] k, input logic [31:0] pos,
		input pos_t len, input logic [7:0] v);
		rec_item_t r;
		r.kind       = k;
		r.position   = pos;
		r.run_length = len;
		r.value      = v;
		r.last       = 1'b0;
		return r;
	endfunction

	task automatic add_rec(input rec_item_t r);
		rec_batch = {rec_batch, r};
	endtask

	task automatic clear_run_state();
		char_idx    = '0;
		low_open    = 1'b0;
		low_len     = '0;
		low_gap     = '0;
		low_anchor  = '0;
		n_open      = 1'b0;
		n_len       = '0;
		n_gap       = '0;
		n_anchor    = '0;
		spec_anchor = '0;
	endtask

	task automatic close_lower(input pos_t i);
		add_rec(make_rec(KIND_LOWER, low_gap, low_len, 8'h00));
		low_anchor = i;
		low_open   = 1'b0;
	endtask

	// Queue the records one character causes and advance the run state.
	task automatic predict_records(input char_item_t it);
		logic [7:0]  c;
		logic        is_low;
		logic        is_base;
		logic [1:0]  code;
		pos_t        i;
		logic [63:0] d;
		rec_item_t   r;
		rec_batch.delete();
		c      = it.ch;
		i      = char_idx;
		is_low = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
		if (is_low) begin
			c = c - CASE_OFFSET;
			if (low_open) begin
				low_len = bump(low_len);
			end else begin
				low_open = 1'b1;
				low_len  = pos_t'(1);
				low_gap  = gap32(i, low_anchor);
			end
		end
		is_base = 1'b1;
		code    = CODE_A;
		case (c)
			CH_A: code = CODE_A;
			CH_C: code = CODE_C;
			CH_G: code = CODE_G;
			CH_T: code = CODE_T;
			default: is_base = 1'b0;
		endcase

		if (ref_mode) begin
			// N-run and special tracking hold while in reference mode
			if (!is_low && low_open)
				close_lower(i);
			if (is_base)
				add_rec(make_rec(KIND_BASE, 32'd0, '0, {6'd0, code}));
			if (it.seq_end && low_open)
				close_lower(i);
		end else begin
			if (is_base) begin
				add_rec(make_rec(KIND_BASE, 32'd0, '0, {6'd0, code}));
			end else if (c == CH_N) begin
				if (n_open) begin
					n_len = bump(n_len);
				end else begin
					n_open = 1'b1;
					n_len  = pos_t'(1);
					n_gap  = gap32(i, n_anchor);
				end
			end else begin
				// a special at index 0 with no earlier one lands at -1
				d = 64'(i) - 64'd1 - 64'(spec_anchor);
				add_rec(make_rec(KIND_SPECIAL, d[31:0], '0, c));
				spec_anchor = i;
			end
			if ((!is_low || it.seq_end) && low_open)
				close_lower(i);
			if ((c != CH_N || it.seq_end) && n_open) begin
				add_rec(make_rec(KIND_NRUN, n_gap, n_len, 8'h00));
				n_anchor = i;
				n_open   = 1'b0;
			end
		end

		foreach (rec_batch[k]) begin
			r          = rec_batch[k];
			r.last     = (k == rec_batch.size() - 1);
			rec_expect = {rec_expect, r};
		end

		if (it.seq_end)
			clear_run_state();
		else
			char_idx = bump(char_idx);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		rec_item_t want;
		if (!arst_n) begin
			ref_mode = 1'b0;
			clear_run_state();
			rec_expect.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// compare before predicting: a character's records show from the next cycle on
			if (rec_valid && !rec_stall) begin
				if (rec_expect.size() == 0) begin
					fail_count++;
					$display("%0t: record with nothing expected: expected none, actual %p",
						$time, rec_item);
				end else begin
					want = rec_expect.pop_front();
					check_field("kind", 32'(want.kind), 32'(rec_item.kind));
					check_field("position", want.position, rec_item.position);
					check_field("run_length", 32'(want.run_length), 32'(rec_item.run_length));
					check_field("value", 32'(want.value), 32'(rec_item.value));
					check_field("last", 32'(want.last), 32'(rec_item.last));
				end
			end
			if (char_valid && !char_stall)
				predict_records(char_item);
			// a mode write applies from the next character on
			if (cfg_valid && cfg_ready)
				ref_mode = cfg_data;
			pending = rec_expect.size();
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for dna_case_n_special_extract
// Drives a directed character set, then random well-formed sequences with
// runs, specials and noise, toggling reference mode between and inside
// sequences. Both channels idle at random. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
	import dnacase_pkg::*;

	localparam int RANDOM_ITEMS  = 300;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int SETTLE_CYCLES = 4;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic       cfg_data   = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	char_item_t char_item  = '0;
	logic       rec_valid;
	logic       rec_stall  = 1'b0;
	rec_item_t  rec_item;

	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	int   stall_left  = 0;
	logic tx_steady   = 1'b0;
	logic rx_steady   = 1'b0;

	logic [7:0] seq_buf[$];

	always #1 clk = ~clk;

	dna_case_n_special_extract u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_item   (rec_item)
	);

	dna_case_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_item   (rec_item),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Record side: draw a stall for the next record after each transaction.
	always @(posedge clk) begin : rec_pace
		int hold;
		if (rec_valid && !rec_stall) begin
			hold = rx_steady ? 0 : $urandom_range(0, 5);
			stall_left <= hold;
			rec_stall  <= (hold != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			rec_stall  <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (rec_valid && !rec_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Handshakes are sampled at the falling edge, where everything is settled.
	task automatic send_char(input logic [7:0] c, input logic last_ch);
		int   gap;
		logic took;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= '{ch: c, seq_end: last_ch};
		do begin
			@(negedge clk);
			took = !char_stall;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_text(input string s, input logic end_last);
		for (int k = 0; k < s.len(); k++)
			send_char(s[k], end_last && (k == s.len() - 1));
	endtask

	// Hold off until every expected record is out and the block has settled.
	task automatic drain();
		char_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		logic took;
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] seg_char(input int cls);
		logic [7:0] bases[4];
		bases = '{CH_A, CH_C, CH_G, CH_T};
		case (cls)
			0: return bases[$urandom_range(0, 3)];
			1: return ($urandom_range(0, 3) == 0) ? 8'(CH_LOW_A + $urandom_range(0, 25)) :
				bases[$urandom_range(0, 3)] + CASE_OFFSET;
			2: return CH_N;
			3: return CH_N + CASE_OFFSET;
			4: return 8'(CH_A + $urandom_range(0, 25));
			default: return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
				8'(8'h21 + $urandom_range(0, 31));
		endcase
	endfunction

	// Fill seq_buf with runs of similar characters, or with plain noise.
	task automatic build_sequence();
		int cls;
		int reps;
		seq_buf.delete();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 10)) seq_buf = {seq_buf, 8'($urandom_range(0, 255))};
		end else begin
			repeat ($urandom_range(1, 8)) begin
				cls  = $urandom_range(0, 6);
				reps = (cls >= 5) ? $urandom_range(1, 2) : $urandom_range(1, 6);
				repeat (reps) seq_buf = {seq_buf, seg_char(cls)};
			end
		end
	endtask

	initial begin : stimulus
		int sent;
		int split;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: special at index 0, bases, case runs, N runs, byte extremes
		write_mode(1'b0);
		send_text("!ACGTacgtNN", 1'b0);
		send_char(8'h00, 1'b0);
		send_text("n", 1'b0);
		send_char(8'hff, 1'b0);
		send_text("zZ", 1'b0);
		send_text("n", 1'b1);
		// leave an N run open across reference mode, then pick it up again
		send_text("NN", 1'b0);
		write_mode(1'b1);
		send_text("gT@", 1'b0);
		write_mode(1'b0);
		send_text("NA", 1'b0);
		write_mode(1'b1);
		send_text("a", 1'b0);
		send_char(8'h80, 1'b0);
		send_text("t", 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			build_sequence();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				write_mode(1'($urandom_range(0, 1)));
			else if ($urandom_range(0, 14) == 0)
				drain();
			split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, seq_buf.size() - 1) : -1;
			foreach (seq_buf[k]) begin
				if (k == split)
					write_mode(1'($urandom_range(0, 1)));
				send_char(seq_buf[k], k == seq_buf.size() - 1);
				sent++;
			end
		end

		drain();
		repeat (6) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
